/* rtl/core/tkct_pkg.sv */
// Package for the top-K count tracker: entry and result types, field widths,
// function codes. No dependencies; every other file of the block imports it.
package tkct_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam logic [DATA_W-1:0]  SAT_MAX     = 32'hFFFF_FFFF;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_READOUT = 1'b1;

    // one stored pair, as held in the entry memory
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] phrase;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [DATA_W-1:0] phrase_id_res;
        logic [DATA_W-1:0] occurrences_res;
        logic              is_summary;
        logic [DATA_W-1:0] total;
        logic              last;
    } t_result;

endpackage

/* rtl/core/tkct_in_if.sv */
// Input channel of the top-K count tracker: valid/ready plus one item.
// Depends on tkct_pkg for field widths.
interface tkct_in_if import tkct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [DATA_W-1:0] phrase_id;
    logic [DATA_W-1:0] occurrences;

    modport source (output valid, func, phrase_id, occurrences, input ready);
    modport sink   (input valid, func, phrase_id, occurrences, output ready);
endinterface

/* rtl/core/tkct_out_if.sv */
// Result channel of the top-K count tracker: valid/ready plus one result.
// Depends on tkct_pkg for field widths.
interface tkct_out_if import tkct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] phrase_id_res;
    logic [DATA_W-1:0] occurrences_res;
    logic              is_summary;
    logic [DATA_W-1:0] total;
    logic              last;

    modport source (output valid, phrase_id_res, occurrences_res, is_summary, total, last,
                    input ready);
    modport sink   (input valid, phrase_id_res, occurrences_res, is_summary, total, last,
                    output ready);
endinterface

/* rtl/core/tkct_cfg_if.sv */
// Configuration write channel of the top-K count tracker: valid/ready plus
// the keep_limit write data. Depends on tkct_pkg for the width.
interface tkct_cfg_if import tkct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] keep_limit;

    modport source (output valid, keep_limit, input ready);
    modport sink   (input valid, keep_limit, output ready);
endinterface

/* rtl/core/top_k_count_tracker_top.sv */
// Top level of the top-K count tracker: sequencer plus entry memory.
// Depends on tkct_pkg, tkct_in_if, tkct_out_if, tkct_cfg_if, tkct_mem, tkct_seq.
//
//  channel   dir  beat contents
//  i_in      in   func, phrase_id, occurrences
//  o_out     out  phrase_id_res, occurrences_res, is_summary, total, last
//  i_cfg     in   keep_limit
//
// One item at a time; the entry memory port walks one entry per cycle (on readout
// only while results are taken). Insert: from pass-through, empty table or drop
// up to a shift through every stored entry; readout: every entry plus summary.
// Synchronous active-low reset clears fill level, pass count and limit (16);
// entry memory is not cleared, only entries below the fill level are read.
// A stalled result holds the sequencer in pass and readout; inputs are taken when idle.
module top_k_count_tracker_top import tkct_pkg::*; #(
    parameter int unsigned MAX_KEEP = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tkct_in_if.sink    i_in,
    tkct_out_if.source o_out,
    tkct_cfg_if.sink   i_cfg
);

    localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    tkct_seq #(
        .MAX_KEEP (MAX_KEEP),
        .AW       (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cfg     (i_cfg),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    tkct_mem #(
        .DEPTH (MAX_KEEP),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

/* rtl/core/tkct_mem.sv */
// Entry memory: one write port, one read port, registered read data.
// Depends on tkct_pkg for the entry type.
module tkct_mem import tkct_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/tkct_seq.sv */
// Sequencer of the top-K count tracker: walks the sorted entry memory for
// inserts and readouts, owns fill level, pass count, limit and result register.
// Depends on tkct_pkg and the three channel interfaces.
module tkct_seq import tkct_pkg::*; #(
    parameter int unsigned MAX_KEEP = 16,
    parameter int unsigned AW       = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tkct_in_if.sink       i_in,
    tkct_out_if.source    o_out,
    tkct_cfg_if.sink      i_cfg,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_entry        i_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_entry        o_wr_data
);

    localparam int unsigned FW = $clog2(MAX_KEEP + 1);
    localparam int unsigned CW = (FW > LIMIT_W) ? FW : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_EV_CHK,
        ST_INS_UP,
        ST_INS_DN,
        ST_PLACE,
        ST_RO_EMIT,
        ST_RO_SUM
    } t_state;

    t_state             r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_idx, n_idx;
    logic               r_grow, n_grow;
    logic [DATA_W-1:0]  r_passed, n_passed;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    t_entry             r_item, n_item;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic [CW-1:0] w_lim;
    logic          w_full;
    logic          w_out_free;
    logic [FW-1:0] w_fill_m1;
    logic [FW-1:0] w_idx_up;
    logic [FW-1:0] w_idx_dn;

    // limit above capacity acts as capacity
    assign w_lim = (CW'(r_limit) > CW'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(r_limit);
    assign w_full     = CW'(r_fill) >= w_lim;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fill_m1  = r_fill - FW'(1);
    assign w_idx_up   = r_idx + FW'(1);
    assign w_idx_dn   = r_idx - FW'(1);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_out_valid;
    assign o_out.phrase_id_res   = r_out.phrase_id_res;
    assign o_out.occurrences_res = r_out.occurrences_res;
    assign o_out.is_summary      = r_out.is_summary;
    assign o_out.total           = r_out.total;
    assign o_out.last            = r_out.last;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_grow      = r_grow;
        n_passed    = r_passed;
        n_limit     = r_limit;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = r_item;

        if (i_cfg.valid) begin
            n_limit = i_cfg.keep_limit;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_item.count  = i_in.occurrences;
                    n_item.phrase = i_in.phrase_id;
                    if (i_in.func == FUNC_READOUT) begin
                        if (r_fill == '0) begin
                            n_state = ST_RO_SUM;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = w_fill_m1[AW-1:0];
                            n_idx     = w_fill_m1;
                            n_state   = ST_RO_EMIT;
                        end
                    end else if (w_lim == '0) begin
                        if (r_passed != SAT_MAX) begin
                            n_passed = r_passed + DATA_W'(1);
                        end
                        n_state = ST_PASS;
                    end else if (w_full) begin
                        // full: look at the smallest (oldest on ties) entry first
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_grow    = 1'b0;
                        n_state   = ST_EV_CHK;
                    end else if (r_fill == '0) begin
                        n_idx   = '0;
                        n_grow  = 1'b1;
                        n_state = ST_PLACE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_fill_m1[AW-1:0];
                        n_idx     = w_fill_m1;
                        n_grow    = 1'b1;
                        n_state   = ST_INS_DN;
                    end
                end
            end
            ST_PASS: begin
                if (w_out_free) begin
                    n_out.phrase_id_res   = r_item.phrase;
                    n_out.occurrences_res = r_item.count;
                    n_out.is_summary      = 1'b0;
                    n_out.total           = r_passed;
                    n_out.last            = 1'b1;
                    n_out_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            ST_EV_CHK: begin
                if (i_rd_data.count >= r_item.count) begin
                    n_state = ST_IDLE;
                end else if (r_fill == FW'(1)) begin
                    n_idx   = '0;
                    n_state = ST_PLACE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(1);
                    n_idx     = FW'(1);
                    n_state   = ST_INS_UP;
                end
            end
            ST_INS_UP: begin
                // evicting walk: entries not above the new count slide down
                if (i_rd_data.count <= r_item.count) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_dn[AW-1:0];
                    o_wr_data = i_rd_data;
                    if (r_idx == w_fill_m1) begin
                        n_state = ST_PLACE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_idx_up[AW-1:0];
                        n_idx     = w_idx_up;
                    end
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_dn[AW-1:0];
                    n_state   = ST_IDLE;
                end
            end
            ST_INS_DN: begin
                // growing walk from the top: larger entries slide up
                if (i_rd_data.count > r_item.count) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_up[AW-1:0];
                    o_wr_data = i_rd_data;
                    if (r_idx == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_idx_dn[AW-1:0];
                        n_idx     = w_idx_dn;
                    end
                end else begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_idx_up[AW-1:0];
                    n_fill    = r_fill + FW'(1);
                    n_state   = ST_IDLE;
                end
            end
            ST_PLACE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx[AW-1:0];
                if (r_grow) begin
                    n_fill = r_fill + FW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_RO_EMIT: begin
                if (w_out_free) begin
                    n_out.phrase_id_res   = i_rd_data.phrase;
                    n_out.occurrences_res = i_rd_data.count;
                    n_out.is_summary      = 1'b0;
                    n_out.total           = '0;
                    n_out.last            = 1'b0;
                    n_out_valid           = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_RO_SUM;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = w_idx_dn[AW-1:0];
                        n_idx     = w_idx_dn;
                    end
                end
            end
            ST_RO_SUM: begin
                if (w_out_free) begin
                    n_out.phrase_id_res   = '0;
                    n_out.occurrences_res = '0;
                    n_out.is_summary      = 1'b1;
                    n_out.total           = (w_lim != '0) ? DATA_W'(r_fill) : r_passed;
                    n_out.last            = 1'b1;
                    n_out_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_grow <= n_grow;
        r_item <= n_item;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_passed    <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_passed    <= n_passed;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= CW'(MAX_KEEP))
        else $error("fill level above capacity");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != $past(r_fill) |-> r_fill == $past(r_fill) + FW'(1))
        else $error("fill level moved by other than one up");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en && o_wr_en |-> o_rd_addr != o_wr_addr)
        else $error("read and write to the same entry in one cycle");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> CW'(o_wr_addr) < CW'(MAX_KEEP))
        else $error("entry write beyond capacity");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_summary |-> r_out.last)
        else $error("summary beat without last");
`endif

endmodule
